// File: hdl/ldci_pkg.sv
package ldci_pkg;

    localparam int FRAC_BITS  = 16;
    localparam int CUTOFF     = 32;
    localparam int X_FRAC     = 16;
    localparam int X_W        = 32;
    localparam int LOG_W      = 24;
    localparam int MODE_W     = 2;
    localparam int Q_FRAC     = 30;
    localparam int Q_W        = Q_FRAC + 1;
    localparam int CNT_W      = $clog2(FRAC_BITS);
    localparam int IP_W       = $clog2(CUTOFF + 1);
    localparam int POS_W      = $clog2(X_W);
    localparam int AREA_W     = 32;
    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_AW    = $clog2(FIFO_DEPTH);

    localparam logic signed [LOG_W-1:0] ZERO_CODE   = {1'b1, {(LOG_W-1){1'b0}}};
    localparam logic signed [LOG_W-1:0] MAX_CODE    = {1'b0, {(LOG_W-1){1'b1}}};
    localparam logic signed [LOG_W-1:0] MIN_NONZERO = {1'b1, {(LOG_W-2){1'b0}}, 1'b1};
    localparam logic [Q_W:0]            ONE_Q       = (Q_W+1)'(1) << Q_FRAC;
    localparam logic [31:0]             CUT_LIM     = 32'(CUTOFF) << FRAC_BITS;

    localparam logic [MODE_W-1:0] MODE_SUM   = 2'd0;
    localparam logic [MODE_W-1:0] MODE_UPPER = 2'd1;

    typedef enum logic [1:0] {
        OP_SUM,
        OP_AREA,
        OP_HOLD
    } op_kind_t;

    typedef struct packed {
        op_kind_t                 kind;
        logic [X_W-1:0]           x;
        logic signed [LOG_W-1:0]  val;
        logic [X_W-1:0]           gap;
        logic                     last;
    } ldci_op_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_NORM,
        ST_GLOG,
        ST_AREA,
        ST_ADD,
        ST_CMUL,
        ST_CSHIFT,
        ST_CLOG,
        ST_FIN,
        ST_OUT
    } back_state_t;

    typedef logic [FRAC_BITS-1:0][Q_W-1:0] root_tab_t;

    // Bit-by-bit integer square root, evaluated at elaboration only.
    function automatic logic [63:0] isqrt64(input logic [63:0] v);
        logic [63:0] r;
        logic [63:0] b;
        logic [63:0] rem;
        r   = '0;
        b   = 64'd1 << 62;
        rem = v;
        for (int i = 0; i < 32; i++)
        begin
            if (rem >= r + b)
            begin
                rem = rem - (r + b);
                r   = (r >> 1) + b;
            end
            else
            begin
                r = r >> 1;
            end
            b = b >> 2;
        end
        return r;
    endfunction

    // Entry k holds 2^(-2^-(k+1)) in Q30, each the square root of the one before.
    function automatic root_tab_t build_roots();
        root_tab_t   t;
        logic [63:0] cur;
        cur  = isqrt64(64'd1 << (2 * Q_FRAC - 1));
        t[0] = cur[Q_W-1:0];
        for (int i = 1; i < FRAC_BITS; i++)
        begin
            cur  = isqrt64(cur << Q_FRAC);
            t[i] = cur[Q_W-1:0];
        end
        return t;
    endfunction

    localparam root_tab_t ROOT_TAB = build_roots();

endpackage

// File: hdl/ldci_front.sv
module ldci_front (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            push,
    input  logic [ldci_pkg::X_W-1:0]        x_pos,
    input  logic signed [ldci_pkg::LOG_W-1:0] log_value,
    input  logic                            end_of_curve,
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [ldci_pkg::MODE_W-1:0]     cfg_data,
    input  logic                            fifo_full,
    output logic                            fifo_wr,
    output ldci_pkg::ldci_op_t              fifo_wdata
);
    import ldci_pkg::*;

    logic [MODE_W-1:0]       mode_reg;
    logic [X_W-1:0]          prev_x_reg;
    logic signed [LOG_W-1:0] prev_log_reg;
    logic                    have_prev_reg;

    logic                    accept;
    logic signed [LOG_W-1:0] pick;

    assign cfg_ready = 1'b1;
    assign accept    = push && !fifo_full;

    always_comb
    begin
        if (mode_reg == MODE_UPPER)
        begin
            pick = (prev_log_reg > log_value) ? prev_log_reg : log_value;
        end
        else
        begin
            pick = (prev_log_reg < log_value) ? prev_log_reg : log_value;
        end
    end

    // The first point of an area curve only primes the previous-point state.
    always_comb
    begin
        fifo_wdata.x    = x_pos;
        fifo_wdata.last = end_of_curve;
        fifo_wdata.gap  = x_pos - prev_x_reg;
        fifo_wdata.val  = log_value;
        fifo_wdata.kind = OP_SUM;
        fifo_wr         = 1'b0;
        if (mode_reg == MODE_SUM)
        begin
            fifo_wr = accept;
        end
        else if (have_prev_reg)
        begin
            fifo_wr = accept;
            if (pick != ZERO_CODE && x_pos > prev_x_reg)
            begin
                fifo_wdata.kind = OP_AREA;
                fifo_wdata.val  = pick;
            end
            else
            begin
                fifo_wdata.kind = OP_HOLD;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg      <= MODE_SUM;
            prev_x_reg    <= '0;
            prev_log_reg  <= ZERO_CODE;
            have_prev_reg <= 1'b0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                mode_reg <= cfg_data;
            end
            if (accept)
            begin
                if (end_of_curve)
                begin
                    prev_x_reg    <= '0;
                    prev_log_reg  <= ZERO_CODE;
                    have_prev_reg <= 1'b0;
                end
                else
                begin
                    prev_x_reg    <= x_pos;
                    prev_log_reg  <= log_value;
                    have_prev_reg <= 1'b1;
                end
            end
        end
    end

endmodule

// File: hdl/ldci_fifo.sv
module ldci_fifo (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               wr,
    input  ldci_pkg::ldci_op_t wdata,
    input  logic               rd,
    output ldci_pkg::ldci_op_t rdata,
    output logic               full,
    output logic               empty
);
    import ldci_pkg::*;

    ldci_op_t             mem [FIFO_DEPTH];
    logic [FIFO_AW-1:0]   wr_ptr_reg;
    logic [FIFO_AW-1:0]   rd_ptr_reg;
    logic [FIFO_AW:0]     count_reg;

    assign full  = (count_reg == (FIFO_AW+1)'(FIFO_DEPTH));
    assign empty = (count_reg == '0);
    assign rdata = mem[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (wr && !full)
        begin
            mem[wr_ptr_reg] <= wdata;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (wr && !full)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (rd && !empty)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            if ((wr && !full) && !(rd && !empty))
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (!(wr && !full) && (rd && !empty))
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= (FIFO_AW+1)'(FIFO_DEPTH))
        else $error("queue count beyond depth");

    a_count_up: assert property (@(posedge clk) disable iff (!rst_n)
        (wr && !full && !rd) |=> count_reg == $past(count_reg) + 1'b1)
        else $error("queue count did not follow a write");

endmodule

// File: hdl/ldci_back.sv
module ldci_back (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            fifo_empty,
    input  ldci_pkg::ldci_op_t              fifo_rdata,
    output logic                            fifo_rd,
    input  logic                            pop,
    output logic                            empty,
    output logic [ldci_pkg::X_W-1:0]        out_x,
    output logic signed [ldci_pkg::LOG_W-1:0] log_sum,
    output logic                            last_point
);
    import ldci_pkg::*;

    back_state_t             state_reg, state_next;
    logic [X_W-1:0]          x_reg, x_next;
    logic                    last_reg, last_next;
    logic signed [LOG_W-1:0] val_reg, val_next;
    logic [X_W-1:0]          gap_reg, gap_next;
    logic [Q_W-1:0]          acc_reg, acc_next;
    logic [FRAC_BITS:0]      res_reg, res_next;
    logic [POS_W-1:0]        exp_reg, exp_next;
    logic [FRAC_BITS-1:0]    frac_reg, frac_next;
    logic [IP_W-1:0]         ip_reg, ip_next;
    logic signed [LOG_W-1:0] hi_reg, hi_next;
    logic [CNT_W-1:0]        cnt_reg, cnt_next;
    logic signed [LOG_W-1:0] sum_reg, sum_next;
    logic signed [LOG_W-1:0] r_reg, r_next;
    logic                    out_valid_reg, out_valid_next;
    logic [X_W-1:0]          out_x_reg, out_x_next;
    logic signed [LOG_W-1:0] out_sum_reg, out_sum_next;
    logic                    out_last_reg, out_last_next;

    logic                    out_free;
    logic                    out_load;
    logic                    cnt_end;
    logic [Q_W-1:0]          mul_b;
    logic [2*Q_W-1:0]        prod;
    logic [Q_W:0]            sq_t;
    logic                    sq_bit;
    logic [Q_W-1:0]          sq_m;
    logic [Q_W-1:0]          mul_q;
    logic [POS_W-1:0]        msb_pos;
    logic [X_W-1:0]          norm;
    logic signed [AREA_W-1:0] area_full;
    logic signed [LOG_W-1:0] area_sat;
    logic signed [LOG_W-1:0] hi, lo;
    logic [LOG_W:0]          diff;
    logic [Q_W-1:0]          y_shift;
    logic [Q_W:0]            s_sum;
    logic signed [AREA_W-1:0] fin_full;
    logic signed [LOG_W-1:0] fin_sat;

    assign out_free = !out_valid_reg || pop;
    assign out_load = (state_reg == ST_OUT) && out_free;
    assign cnt_end  = (cnt_reg == CNT_W'(FRAC_BITS - 1));

    // One shared multiplier: squaring for log2, table products for 2^-f.
    assign mul_b  = (state_reg == ST_CMUL) ? ROOT_TAB[cnt_reg] : acc_reg;
    assign prod   = acc_reg * mul_b;
    assign sq_t   = prod[2*Q_W-1:Q_FRAC];
    assign sq_bit = sq_t[Q_W];
    assign sq_m   = sq_bit ? sq_t[Q_W:1] : sq_t[Q_W-1:0];
    assign mul_q  = prod[Q_FRAC+Q_W-1:Q_FRAC];

    // Leading-one position of the x gap and the gap normalized into [1,2) Q30.
    always_comb
    begin
        msb_pos = '0;
        for (int i = 0; i < X_W; i++)
        begin
            if (gap_reg[i])
            begin
                msb_pos = POS_W'(i);
            end
        end
        norm = gap_reg << (POS_W'(X_W - 1) - msb_pos);
    end

    always_comb
    begin
        area_full = AREA_W'(val_reg)
                  + ((AREA_W'(signed'({1'b0, exp_reg})) - AREA_W'(X_FRAC)) <<< FRAC_BITS)
                  + AREA_W'(signed'({1'b0, res_reg}));
        if (area_full > AREA_W'(MAX_CODE))
        begin
            area_sat = MAX_CODE;
        end
        else if (area_full < AREA_W'(MIN_NONZERO))
        begin
            area_sat = MIN_NONZERO;
        end
        else
        begin
            area_sat = area_full[LOG_W-1:0];
        end
    end

    always_comb
    begin
        hi      = (sum_reg > val_reg) ? sum_reg : val_reg;
        lo      = (sum_reg > val_reg) ? val_reg : sum_reg;
        diff    = {hi[LOG_W-1], hi} - {lo[LOG_W-1], lo};
        y_shift = acc_reg >> ip_reg;
        s_sum   = ONE_Q + {1'b0, y_shift};
    end

    always_comb
    begin
        fin_full = AREA_W'(hi_reg) + AREA_W'(signed'({1'b0, res_reg}));
        if (fin_full > AREA_W'(MAX_CODE))
        begin
            fin_sat = MAX_CODE;
        end
        else
        begin
            fin_sat = fin_full[LOG_W-1:0];
        end
    end

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (!fifo_empty)
                begin
                    case (fifo_rdata.kind)
                        OP_SUM:  state_next = ST_ADD;
                        OP_AREA: state_next = ST_NORM;
                        default: state_next = ST_OUT;
                    endcase
                end
            end
            ST_NORM:   state_next = ST_GLOG;
            ST_GLOG:   state_next = cnt_end ? ST_AREA : ST_GLOG;
            ST_AREA:   state_next = ST_ADD;
            ST_ADD:
            begin
                if (sum_reg == ZERO_CODE || val_reg == ZERO_CODE ||
                    32'(diff) > CUT_LIM)
                begin
                    state_next = ST_OUT;
                end
                else
                begin
                    state_next = ST_CMUL;
                end
            end
            ST_CMUL:   state_next = cnt_end ? ST_CSHIFT : ST_CMUL;
            ST_CSHIFT: state_next = s_sum[Q_W] ? ST_FIN : ST_CLOG;
            ST_CLOG:   state_next = cnt_end ? ST_FIN : ST_CLOG;
            ST_FIN:    state_next = ST_OUT;
            ST_OUT:    state_next = out_free ? ST_IDLE : ST_OUT;
            default:   state_next = ST_IDLE;
        endcase
    end

    // Datapath and output register.
    always_comb
    begin
        fifo_rd        = 1'b0;
        x_next         = x_reg;
        last_next      = last_reg;
        val_next       = val_reg;
        gap_next       = gap_reg;
        acc_next       = acc_reg;
        res_next       = res_reg;
        exp_next       = exp_reg;
        frac_next      = frac_reg;
        ip_next        = ip_reg;
        hi_next        = hi_reg;
        cnt_next       = cnt_reg;
        sum_next       = sum_reg;
        r_next         = r_reg;
        out_valid_next = out_valid_reg && !pop;
        out_x_next     = out_x_reg;
        out_sum_next   = out_sum_reg;
        out_last_next  = out_last_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (!fifo_empty)
                begin
                    fifo_rd   = 1'b1;
                    x_next    = fifo_rdata.x;
                    last_next = fifo_rdata.last;
                    val_next  = $signed(fifo_rdata.val);
                    gap_next  = fifo_rdata.gap;
                    r_next    = sum_reg;
                end
            end
            ST_NORM:
            begin
                acc_next = norm[X_W-1:1];
                exp_next = msb_pos;
                res_next = '0;
                cnt_next = '0;
            end
            ST_GLOG, ST_CLOG:
            begin
                acc_next = sq_m;
                res_next = {res_reg[FRAC_BITS-1:0], sq_bit};
                cnt_next = cnt_reg + 1'b1;
            end
            ST_AREA:
            begin
                val_next = area_sat;
            end
            ST_ADD:
            begin
                if (sum_reg == ZERO_CODE)
                begin
                    r_next = val_reg;
                end
                else if (val_reg == ZERO_CODE)
                begin
                    r_next = sum_reg;
                end
                else
                begin
                    r_next = hi;
                end
                hi_next   = hi;
                frac_next = diff[FRAC_BITS-1:0];
                ip_next   = IP_W'(diff >> FRAC_BITS);
                acc_next  = ONE_Q[Q_W-1:0];
                cnt_next  = '0;
            end
            ST_CMUL:
            begin
                if (frac_reg[FRAC_BITS-1])
                begin
                    acc_next = mul_q;
                end
                frac_next = frac_reg << 1;
                cnt_next  = cnt_reg + 1'b1;
            end
            ST_CSHIFT:
            begin
                // A zero difference gives a correction of exactly one.
                if (s_sum[Q_W])
                begin
                    res_next = (FRAC_BITS+1)'(1) << FRAC_BITS;
                end
                else
                begin
                    acc_next = s_sum[Q_W-1:0];
                    res_next = '0;
                    cnt_next = '0;
                end
            end
            ST_FIN:
            begin
                r_next = fin_sat;
            end
            ST_OUT:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_x_next     = x_reg;
                    out_sum_next   = r_reg;
                    out_last_next  = last_reg;
                    sum_next       = last_reg ? ZERO_CODE : r_reg;
                end
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            sum_reg       <= ZERO_CODE;
            out_valid_reg <= 1'b0;
            cnt_reg       <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            sum_reg       <= sum_next;
            out_valid_reg <= out_valid_next;
            cnt_reg       <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        x_reg        <= x_next;
        last_reg     <= last_next;
        val_reg      <= val_next;
        gap_reg      <= gap_next;
        acc_reg      <= acc_next;
        res_reg      <= res_next;
        exp_reg      <= exp_next;
        frac_reg     <= frac_next;
        ip_reg       <= ip_next;
        hi_reg       <= hi_next;
        r_reg        <= r_next;
        out_x_reg    <= out_x_next;
        out_sum_reg  <= out_sum_next;
        out_last_reg <= out_last_next;
    end

    assign empty      = !out_valid_reg;
    assign out_x      = out_x_reg;
    assign log_sum    = out_sum_reg;
    assign last_point = out_last_reg;

    a_out_wait: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_OUT && out_valid_reg && !pop) |=> state_reg == ST_OUT)
        else $error("result dropped while the output register was occupied");

    a_curve_clear: assert property (@(posedge clk) disable iff (!rst_n)
        (out_load && last_reg) |=> sum_reg == ZERO_CODE)
        else $error("running sum not cleared at the end of a curve");

    a_shift_order: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_CSHIFT) |-> $past(state_reg) == ST_CMUL)
        else $error("correction shift entered without the product pass");

endmodule

// File: hdl/log2_domain_cumulative_integral_top.sv
// Channel   Handshake                     Payload
// -------   ---------------------------   ------------------------------------
// input     push / full                   x_pos, log_value, end_of_curve
// result    pop / empty                   out_x, log_sum, last_point
// config    cfg_valid / cfg_ready         cfg_data (mode)
//
// Points enter a four-deep queue at one per cycle while it has room; the back
// end then takes them one at a time: a point that leaves the sum unchanged goes
// straight to the result register, while a log-add or a strip area steps one
// shared 31x31 multiplier once per fraction bit. Reset clears the running sum,
// the previous point and the mode to 0. A held result stalls the back end only;
// the front keeps taking points until the queue is full.
module log2_domain_cumulative_integral_top (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            push,
    output logic                            full,
    input  logic [ldci_pkg::X_W-1:0]        x_pos,
    input  logic signed [ldci_pkg::LOG_W-1:0] log_value,
    input  logic                            end_of_curve,
    output logic                            empty,
    input  logic                            pop,
    output logic [ldci_pkg::X_W-1:0]        out_x,
    output logic signed [ldci_pkg::LOG_W-1:0] log_sum,
    output logic                            last_point,
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [ldci_pkg::MODE_W-1:0]     cfg_data
);
    import ldci_pkg::*;

    logic     fifo_wr;
    logic     fifo_rd;
    logic     fifo_full;
    logic     fifo_empty;
    ldci_op_t fifo_wdata;
    ldci_op_t fifo_rdata;

    assign full = fifo_full;

    ldci_front u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .push         (push),
        .x_pos        (x_pos),
        .log_value    (log_value),
        .end_of_curve (end_of_curve),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_data     (cfg_data),
        .fifo_full    (fifo_full),
        .fifo_wr      (fifo_wr),
        .fifo_wdata   (fifo_wdata)
    );

    ldci_fifo u_fifo (
        .clk   (clk),
        .rst_n (rst_n),
        .wr    (fifo_wr),
        .wdata (fifo_wdata),
        .rd    (fifo_rd),
        .rdata (fifo_rdata),
        .full  (fifo_full),
        .empty (fifo_empty)
    );

    ldci_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .fifo_empty (fifo_empty),
        .fifo_rdata (fifo_rdata),
        .fifo_rd    (fifo_rd),
        .pop        (pop),
        .empty      (empty),
        .out_x      (out_x),
        .log_sum    (log_sum),
        .last_point (last_point)
    );

endmodule

// File: tb/tb_log2_domain_cumulative_integral_top.sv
`timescale 1ns / 1ps

module tb_log2_domain_cumulative_integral_top;
    import ldci_pkg::*;

    localparam logic [MODE_W-1:0] MODE_LOWER     = 2'd2;
    localparam logic [MODE_W-1:0] MODE_LOWER_ALT = 2'd3;

    localparam int LOG_ZERO      = -(1 << (LOG_W - 1));
    localparam int LOG_MAX       = (1 << (LOG_W - 1)) - 1;
    localparam int LOG_FLOOR     = LOG_ZERO + 1;
    localparam int ONE_LOG       = 1 << FRAC_BITS;
    localparam int SETTLE_CYCLES = 300;
    localparam int RANDOM_ITEMS  = 1150;
    localparam int REPORT_CAP    = 40;

    typedef struct {
        logic [X_W-1:0]          x;
        logic signed [LOG_W-1:0] lv;
        logic                    last;
    } curve_point_t;

    logic                    clk          = 1'b0;
    logic                    rst_n        = 1'b0;
    logic                    push         = 1'b0;
    logic                    full;
    logic [X_W-1:0]          x_pos        = '0;
    logic signed [LOG_W-1:0] log_value    = '0;
    logic                    end_of_curve = 1'b0;
    logic                    empty;
    logic                    pop          = 1'b0;
    logic [X_W-1:0]          out_x;
    logic signed [LOG_W-1:0] log_sum;
    logic                    last_point;
    logic                    cfg_valid    = 1'b0;
    logic                    cfg_ready;
    logic [MODE_W-1:0]       cfg_data     = '0;

    // Predictor state: a copy of the block's mode, running sum and previous point.
    bit [63:0]         half_roots [FRAC_BITS];
    logic [MODE_W-1:0] pred_mode  = MODE_SUM;
    int                acc_log    = LOG_ZERO;
    logic [X_W-1:0]    last_x     = '0;
    int                last_log   = LOG_ZERO;
    bit                seen_point = 1'b0;

    curve_point_t point_queue[$];
    curve_point_t expected_sums[$];
    curve_point_t want_point;

    int error_count      = 0;
    int send_hold        = 0;
    int pop_hold         = 0;
    int gap_len;
    bit sender_idle_on   = 1'b0;
    bit receiver_idle_on = 1'b0;

    log2_domain_cumulative_integral_top u_top (
        .clk          (clk),
        .rst_n        (rst_n),
        .push         (push),
        .full         (full),
        .x_pos        (x_pos),
        .log_value    (log_value),
        .end_of_curve (end_of_curve),
        .empty        (empty),
        .pop          (pop),
        .out_x        (out_x),
        .log_sum      (log_sum),
        .last_point   (last_point),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_data     (cfg_data)
    );

    initial
    begin
        forever #6 clk = ~clk;
    end

    function automatic bit [63:0] int_sqrt(input bit [63:0] v);
        bit [63:0] rem;
        bit [63:0] root;
        bit [63:0] probe;
        rem   = v;
        root  = '0;
        probe = 64'd1 << 62;
        while (probe != 0)
        begin
            if (rem >= root + probe)
            begin
                rem  = rem - (root + probe);
                root = (root >> 1) + probe;
            end
            else
            begin
                root = root >> 1;
            end
            probe = probe >> 2;
        end
        return root;
    endfunction

    // Fraction bits of log2 of a Q30 mantissa in [1,2), by repeated squaring.
    function automatic int frac_log2(input bit [63:0] mant);
        bit [63:0] sq;
        int        bits;
        sq   = mant;
        bits = 0;
        for (int i = 0; i < FRAC_BITS; i++)
        begin
            sq   = (sq * sq) >> Q_FRAC;
            bits = bits << 1;
            if (sq >= (64'd1 << (Q_FRAC + 1)))
            begin
                sq   = sq >> 1;
                bits = bits | 1;
            end
        end
        return bits;
    endfunction

    // Adds two values in the log2 domain: larger one plus log2(1 + 2^-d).
    function automatic int log2_sum(input int a, input int b);
        int        hi;
        int        lo;
        int        diff;
        int        whole;
        int        r;
        bit [63:0] y;
        bit [63:0] s;
        if (a == LOG_ZERO)
            return b;
        if (b == LOG_ZERO)
            return a;
        hi   = (a > b) ? a : b;
        lo   = (a > b) ? b : a;
        diff = hi - lo;
        if (diff > (CUTOFF << FRAC_BITS))
            return hi;
        y = 64'd1 << Q_FRAC;
        for (int i = 0; i < FRAC_BITS; i++)
        begin
            if (diff[FRAC_BITS - 1 - i])
                y = (y * half_roots[i]) >> Q_FRAC;
        end
        whole = diff >> FRAC_BITS;
        y     = (whole >= 31) ? 64'd0 : (y >> whole);
        s     = (64'd1 << Q_FRAC) + y;
        if (s >= (64'd1 << (Q_FRAC + 1)))
            r = hi + ONE_LOG;
        else
            r = hi + frac_log2(s);
        return (r > LOG_MAX) ? LOG_MAX : r;
    endfunction

    // Advances the predicted state by one accepted point and queues its result when it emits one.
    function automatic void integrate_point(input logic [X_W-1:0] x,
                                            input logic signed [LOG_W-1:0] lv_in,
                                            input logic last);
        int           lv;
        int           pick;
        int           msb;
        longint       area;
        bit [31:0]    gap;
        bit [63:0]    mant;
        bit           emit;
        curve_point_t res;
        lv   = lv_in;
        emit = 1'b0;
        if (pred_mode == MODE_SUM)
        begin
            acc_log = log2_sum(acc_log, lv);
            emit    = 1'b1;
        end
        else if (seen_point)
        begin
            if (pred_mode == MODE_UPPER)
                pick = (last_log > lv) ? last_log : lv;
            else
                pick = (last_log < lv) ? last_log : lv;
            if (pick != LOG_ZERO && x > last_x)
            begin
                gap = x - last_x;
                msb = 31;
                while (msb > 0 && !gap[msb])
                    msb--;
                mant = (msb <= Q_FRAC) ? (64'(gap) << (Q_FRAC - msb))
                                       : (64'(gap) >> (msb - Q_FRAC));
                area = longint'(pick) + longint'(msb - X_FRAC) * ONE_LOG + frac_log2(mant);
                if (area > LOG_MAX)
                    area = LOG_MAX;
                if (area < LOG_FLOOR)
                    area = LOG_FLOOR;
                acc_log = log2_sum(acc_log, int'(area));
            end
            emit = 1'b1;
        end
        if (emit)
        begin
            res.x    = x;
            res.lv   = acc_log[LOG_W-1:0];
            res.last = last;
            expected_sums.push_back(res);
        end
        last_x     = x;
        last_log   = lv;
        seen_point = 1'b1;
        if (last)
        begin
            acc_log    = LOG_ZERO;
            last_x     = '0;
            last_log   = LOG_ZERO;
            seen_point = 1'b0;
        end
    endfunction

    function automatic int idle_gap();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 70)
            return 0;
        if (roll < 92)
            return $urandom_range(1, 4);
        if (roll < 98)
            return $urandom_range(5, 20);
        return $urandom_range(30, 120);
    endfunction

    function automatic void queue_point(input logic [X_W-1:0] x, input int lv, input logic last);
        curve_point_t pt;
        pt.x    = x;
        pt.lv   = lv[LOG_W-1:0];
        pt.last = last;
        point_queue.push_back(pt);
    endfunction

    function automatic void flag_mismatch(input string what, input logic [31:0] want,
                                          input logic [31:0] got);
        if (got !== want)
        begin
            if (error_count < REPORT_CAP)
                $display("%0t: %s mismatch: expected %h, actual %h", $time, what, want, got);
            error_count++;
        end
    endfunction

    // Returns once no point is waiting, in flight or expected, after a further settling wait.
    task automatic wait_idle();
        while (point_queue.size() != 0 || push || expected_sums.size() != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic write_mode(input logic [MODE_W-1:0] m);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_data  <= m;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        pred_mode = m;
        @(negedge clk);
    endtask

    // Point driver: one transaction per accepted point, random gaps between them when sender idling is on.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            push <= 1'b0;
        end
        else
        begin
            if (push && !full)
                integrate_point(x_pos, log_value, end_of_curve);
            if (!push || !full)
            begin
                if (send_hold != 0)
                begin
                    send_hold--;
                    push <= 1'b0;
                end
                else if (point_queue.size() == 0)
                begin
                    push <= 1'b0;
                end
                else
                begin
                    gap_len = sender_idle_on ? idle_gap() : 0;
                    if (gap_len != 0)
                    begin
                        send_hold = gap_len - 1;
                        push <= 1'b0;
                    end
                    else
                    begin
                        want_point = point_queue.pop_front();
                        x_pos        <= want_point.x;
                        log_value    <= want_point.lv;
                        end_of_curve <= want_point.last;
                        push         <= 1'b1;
                    end
                end
            end
        end
    end

    // Result monitor: checks each popped transaction against the oldest prediction.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pop <= 1'b0;
        end
        else
        begin
            if (pop && !empty)
            begin
                if (expected_sums.size() == 0)
                begin
                    if (error_count < REPORT_CAP)
                        $display("%0t: unexpected result: expected none, actual x=%h sum=%h last=%b",
                                 $time, out_x, log_sum, last_point);
                    error_count++;
                end
                else
                begin
                    curve_point_t want;
                    want = expected_sums.pop_front();
                    flag_mismatch("out_x", want.x, out_x);
                    flag_mismatch("log_sum", want.lv, log_sum);
                    flag_mismatch("last_point", want.last, last_point);
                end
            end
            if (pop_hold != 0)
            begin
                pop_hold--;
                pop <= 1'b0;
            end
            else
            begin
                int stall;
                stall = receiver_idle_on ? idle_gap() : 0;
                if (stall != 0)
                begin
                    pop_hold = stall - 1;
                    pop <= 1'b0;
                end
                else
                begin
                    pop <= 1'b1;
                end
            end
        end
    end

    initial
    begin
        bit [63:0]         cur;
        bit [X_W-1:0]      x;
        int                queued;
        int                phase_left;
        int                curve_len;
        int                center;
        int                lv;
        int                roll;
        bit                ragged;
        bit                closes;
        logic [MODE_W-1:0] m;

        cur           = int_sqrt(64'd1 << (2 * Q_FRAC - 1));
        half_roots[0] = cur;
        for (int i = 1; i < FRAC_BITS; i++)
        begin
            cur           = int_sqrt(cur << Q_FRAC);
            half_roots[i] = cur;
        end

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Cumulative sum: zero operands, equal values, the cutoff edge and saturation.
        write_mode(MODE_SUM);
        queue_point(32'd0, LOG_ZERO, 1'b0);
        queue_point(32'd1, 0, 1'b0);
        queue_point(32'd2, 0, 1'b0);
        queue_point(32'd3, ONE_LOG - (CUTOFF << FRAC_BITS), 1'b0);
        queue_point(32'd4, ONE_LOG - (CUTOFF << FRAC_BITS) - 1, 1'b0);
        queue_point(32'd5, LOG_FLOOR, 1'b0);
        queue_point(32'd6, LOG_MAX, 1'b0);
        queue_point(32'd7, LOG_MAX, 1'b0);
        queue_point(32'd8, LOG_ZERO, 1'b1);
        queue_point(32'hFFFF_FFFF, LOG_FLOOR, 1'b0);
        queue_point(32'd0, LOG_FLOOR, 1'b1);
        wait_idle();

        // Upper bound: lone closing point, huge gap, zero gap, decreasing x, gap of one.
        write_mode(MODE_UPPER);
        queue_point(32'd100, 0, 1'b1);
        queue_point(32'd0, LOG_ZERO, 1'b0);
        queue_point(32'hFFFF_FFFF, LOG_MAX, 1'b0);
        queue_point(32'hFFFF_FFFF, 5, 1'b0);
        queue_point(32'd16, 5, 1'b0);
        queue_point(32'd17, LOG_ZERO, 1'b1);
        wait_idle();

        // Lower bound: area clamped at the floor, zero codes picked; curve left open.
        write_mode(MODE_LOWER);
        queue_point(32'd0, LOG_FLOOR, 1'b0);
        queue_point(32'd1, LOG_FLOOR, 1'b0);
        queue_point(32'h0001_0000, LOG_ZERO, 1'b0);
        queue_point(32'h0002_0000, 7 * ONE_LOG, 1'b0);
        queue_point(32'h0002_0003, -2 * ONE_LOG, 1'b0);
        wait_idle();

        // The open curve continues under the other lower-bound code.
        write_mode(MODE_LOWER_ALT);
        queue_point(32'h8000_0000, 1000, 1'b1);
        queue_point(32'd0, 3 * ONE_LOG, 1'b0);
        queue_point(32'h0000_8000, 4 * ONE_LOG, 1'b1);
        wait_idle();

        queued = 0;
        while (queued < RANDOM_ITEMS)
        begin
            case ($urandom_range(0, 3))
                0: m = MODE_SUM;
                1: m = MODE_UPPER;
                2: m = MODE_LOWER;
                default: m = MODE_LOWER_ALT;
            endcase
            write_mode(m);
            sender_idle_on   = ($urandom_range(0, 3) != 0);
            receiver_idle_on = ($urandom_range(0, 3) != 0);
            phase_left       = $urandom_range(60, 130);
            while (phase_left > 0)
            begin
                roll = $urandom_range(0, 9);
                if (roll == 0)
                begin
                    queue_point($urandom, int'($urandom), 1'($urandom_range(0, 1)));
                    phase_left--;
                    queued++;
                end
                else
                begin
                    // Ragged curves carry random steps, stray values and early ends.
                    ragged    = (roll == 1);
                    curve_len = $urandom_range(1, 20);
                    if (curve_len > phase_left)
                        curve_len = phase_left;
                    closes = ($urandom_range(0, 3) != 0);
                    x      = $urandom_range(0, 32'h00FF_FFFF);
                    case ($urandom_range(0, 7))
                        0: center = LOG_MAX - int'($urandom_range(0, 4 << FRAC_BITS));
                        1: center = LOG_FLOOR + int'($urandom_range(0, 4 << FRAC_BITS));
                        default: center = int'($urandom_range(0, 80 << FRAC_BITS))
                                          - (40 << FRAC_BITS);
                    endcase
                    for (int k = 0; k < curve_len; k++)
                    begin
                        lv   = center + int'($urandom_range(0, 16 << FRAC_BITS)) - (8 << FRAC_BITS);
                        roll = $urandom_range(0, 19);
                        if (roll == 0)
                            lv = LOG_ZERO;
                        else if (roll == 1)
                            lv = center - int'($urandom_range(CUTOFF - 4, CUTOFF + 4) << FRAC_BITS);
                        else if (ragged && roll < 6)
                            lv = int'($urandom);
                        if (lv > LOG_MAX)
                            lv = LOG_MAX;
                        if (lv < LOG_ZERO)
                            lv = LOG_FLOOR;
                        queue_point(x, lv, (closes && k == curve_len - 1)
                                           || (ragged && $urandom_range(0, 7) == 0));
                        if (ragged)
                        begin
                            x = x + $urandom_range(0, 1 << 20) - (1 << 19);
                        end
                        else
                        begin
                            case ($urandom_range(0, 19))
                                0: x = x;
                                1: x = x + $urandom_range(1, 15);
                                2: x = x + $urandom_range(1 << 20, 1 << 28);
                                default: x = x + $urandom_range(1, 1 << 18);
                            endcase
                        end
                    end
                    phase_left -= curve_len;
                    queued     += curve_len;
                end
            end
            wait_idle();
        end

        if (error_count == 0)
            $display("log2_domain_cumulative_integral_top regression: pass");
        else
            $display("log2_domain_cumulative_integral_top regression: fail");
        $finish;
    end

    initial
    begin
        #20_000_000;
        $display("log2_domain_cumulative_integral_top regression: fail");
        $finish;
    end

endmodule

// File: filelist.f
hdl/ldci_pkg.sv
hdl/ldci_front.sv
hdl/ldci_fifo.sv
hdl/ldci_back.sv
hdl/log2_domain_cumulative_integral_top.sv
tb/tb_log2_domain_cumulative_integral_top.sv
